// ===== rtl/wis_pkg.sv =====
// Shared types and constants for the weighted index sampler.
package wis_pkg;
  localparam int unsigned VocabMax = 4096;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned UniformW = 24;
  localparam int unsigned IndexW   = 12;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 13;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNoRow   = 2'd1;
  localparam logic [StatusW-1:0] StExhaust = 2'd2;

  localparam logic CfgWithRepl = 1'b0;
  localparam logic CfgSamples  = 1'b1;

  typedef struct packed {
    logic load;      // append weight, prefix
    logic clear_row; // restart row before load
    logic srch_init; // begin search
    logic srch_step; // read mid / compare
    logic rb_init;   // zero chosen weight, start rebuild
    logic rb_step;   // rebuild phase: read or write one entry
  } wis_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic rb_done;
  } wis_sts_t;
endpackage

// ===== rtl/wis_datapath.sv =====
// Datapath: weight and prefix memories, search and rebuild units.
module wis_datapath import wis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wis_cmd_t            cmd_i,
  output wis_sts_t            sts_o,
  input  logic [WeightW-1:0]  weight_i,
  input  logic [UniformW-1:0] uniform_i,
  input  logic [CountW-1:0]   row_len_i,
  output logic [IndexW-1:0]   index_o
);
  localparam int unsigned AW = $clog2(VocabMax);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned PW = WeightW + AW;
  localparam int unsigned TW = PW + UniformW;

  logic [WeightW-1:0] wmem [VocabMax];
  logic [PW-1:0]      pmem [VocabMax];

  logic [PW-1:0]  last_prefix_q;          // prefix of last loaded entry
  logic [LW-1:0]  lo_q, hi_q;
  logic [TW-1:0]  target_q;
  logic [PW-1:0]  rd_q;
  logic           rd_vld_q;
  logic [LW-1:0]  mid_q;
  logic [LW-1:0]  rb_i_q;
  logic [PW-1:0]  run_sum;
  logic [LW-1:0]  len;
  logic [LW-1:0]  mid;
  logic [AW-1:0]  rd_addr;
  logic           rb_phase_q;
  logic [WeightW-1:0] wrd_q;

  assign len = row_len_i[LW-1:0];
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // search: issue read one cycle, compare the next; rebuild: step index and phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
      mid_q <= '0;
      rd_vld_q <= 1'b0;
      rb_i_q <= '0;
      rb_phase_q <= 1'b0;
    end else begin
      if (cmd_i.srch_init) begin
        lo_q <= '0;
        hi_q <= len;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.srch_step) begin
        if (!rd_vld_q) begin
          mid_q <= mid;
          rd_vld_q <= (lo_q < hi_q);
        end else begin
          rd_vld_q <= 1'b0;
          if ({rd_q, {UniformW{1'b0}}} >= target_q) hi_q <= mid_q;
          else lo_q <= mid_q + 1'b1;
        end
      end
      if (cmd_i.rb_init) begin
        rb_i_q <= {1'b0, index_o[AW-1:0]};
        rb_phase_q <= 1'b0;
      end else if (cmd_i.rb_step) begin
        rb_phase_q <= ~rb_phase_q;
        if (rb_phase_q) rb_i_q <= rb_i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_init) target_q <= TW'(uniform_i) * TW'(last_prefix_q);
  end

  assign sts_o.srch_done = cmd_i.srch_step && !rd_vld_q && !(lo_q < hi_q);
  assign sts_o.rb_done   = cmd_i.rb_step && !rb_phase_q && !(rb_i_q < len);
  assign index_o = (lo_q >= len) ? '0 : IndexW'(lo_q);

  assign rd_addr = cmd_i.rb_step ? rb_i_q[AW-1:0] - 1'b1 : mid[AW-1:0];
  assign run_sum = ((rb_i_q == '0) ? '0 : rd_q) + PW'(wrd_q);

  // memories; rebuild phase 0 reads prefix[i-1] and weight[i], phase 1 writes
  always_ff @(posedge clk_i) begin
    rd_q <= pmem[rd_addr];
    wrd_q <= wmem[rb_i_q[AW-1:0]];
    if (cmd_i.load && (cmd_i.clear_row || len < LW'(VocabMax))) begin
      wmem[cmd_i.clear_row ? '0 : len[AW-1:0]] <= weight_i;
      pmem[cmd_i.clear_row ? '0 : len[AW-1:0]] <=
        (cmd_i.clear_row || len == '0) ? PW'(weight_i) : last_prefix_q + PW'(weight_i);
      last_prefix_q <= (cmd_i.clear_row || len == '0) ? PW'(weight_i)
                                                      : last_prefix_q + PW'(weight_i);
    end
    if (cmd_i.rb_init) wmem[index_o[AW-1:0]] <= '0;
    if (cmd_i.rb_step && rb_phase_q) begin
      pmem[rb_i_q[AW-1:0]] <= run_sum;
      if (rb_i_q == len - 1'b1) last_prefix_q <= run_sum;
    end
  end
endmodule

// ===== rtl/wis_ctrl.sv =====
// Controller: request sequencing, row bookkeeping and result register.
module wis_ctrl import wis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic                last_weight_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IndexW-1:0]   index_o,
  output logic [StatusW-1:0]  status_o,
  output logic                last_sample_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CountW-1:0]   cfg_data_i,
  output wis_cmd_t            dp_cmd_o,
  input  wis_sts_t            dp_sts_i,
  input  logic [IndexW-1:0]   dp_index_i,
  output logic [CountW-1:0]   row_len_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SSrch = 2'd1;
  localparam logic [1:0] SRb   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] len_q, done_q, spr_q, quota, done_inc;
  logic              ready_q, repl_q, last_q;
  logic              out_v_q;
  logic [IndexW-1:0] idx_q;
  logic [StatusW-1:0] st_q;
  logic              acc, is_load, is_draw, clr;

  assign in_ready_o  = (state_q == SIdle) && !out_v_q;
  assign cfg_ready_o = 1'b1;
  assign acc     = in_valid_i && in_ready_o;
  assign is_load = acc && !cmd_i;
  assign is_draw = acc && cmd_i;
  assign clr     = ready_q;
  assign quota   = (spr_q == '0) ? CountW'(1) : spr_q;
  assign done_inc = done_q + 1'b1;
  assign row_len_o = len_q;

  always_comb begin
    dp_cmd_o = '0;
    dp_cmd_o.load = is_load;
    dp_cmd_o.clear_row = clr;
    dp_cmd_o.srch_init = is_draw;
    dp_cmd_o.srch_step = (state_q == SSrch);
    dp_cmd_o.rb_init = (state_q == SSrch) && dp_sts_i.srch_done && !repl_q;
    dp_cmd_o.rb_step = (state_q == SRb);
    state_d = state_q;
    case (state_q)
      SIdle: if (is_draw && ready_q && !(!repl_q && done_q >= len_q)) state_d = SSrch;
      SSrch: if (dp_sts_i.srch_done) state_d = repl_q ? SIdle : SRb;
      SRb:   if (dp_sts_i.rb_done) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      len_q <= '0;
      done_q <= '0;
      ready_q <= 1'b0;
      repl_q <= 1'b1;
      spr_q <= CountW'(1);
      out_v_q <= 1'b0;
      last_q <= 1'b0;
      st_q <= StOk;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgWithRepl) repl_q <= cfg_data_i[0];
        else spr_q <= cfg_data_i;
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (is_load) begin
        if (clr) begin
          len_q <= CountW'(1);
          done_q <= '0;
          ready_q <= last_weight_i;
        end else begin
          if (len_q < CountW'(VocabMax)) len_q <= len_q + 1'b1;
          if (last_weight_i) begin
            ready_q <= 1'b1;
            done_q <= '0;
          end
        end
      end
      if (is_draw) begin
        idx_q <= '0;
        if (!ready_q) begin
          st_q <= StNoRow;
          last_q <= 1'b0;
          out_v_q <= 1'b1;
        end else begin
          done_q <= done_inc;
          last_q <= (done_inc >= quota);
          if (done_inc >= quota) ready_q <= 1'b0;
          if (!repl_q && done_q >= len_q) begin
            st_q <= StExhaust;
            out_v_q <= 1'b1;
          end else begin
            st_q <= StOk;
          end
        end
      end
      if (state_q == SSrch && dp_sts_i.srch_done) begin
        idx_q <= dp_index_i;
        if (repl_q) out_v_q <= 1'b1;
      end
      if (state_q == SRb && dp_sts_i.rb_done) out_v_q <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign index_o = idx_q;
  assign status_o = st_q;
  assign last_sample_o = last_q;
endmodule

// ===== rtl/weighted_index_sampler_top.sv =====
// Top level of the weighted index sampler.
// A draw runs a binary search over the prefix memory, each probe reading
// through its single read port and then comparing. Without replacement the
// prefixes from the drawn index to the row end are rebuilt, each entry in a
// read phase and a write phase. One request is worked at a time; the next is
// taken once the result has been taken.
module weighted_index_sampler_top import wis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [WeightW-1:0]  weight_i,
  input  logic                last_weight_i,
  input  logic [UniformW-1:0] uniform_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IndexW-1:0]   index_o,
  output logic [StatusW-1:0]  status_o,
  output logic                last_sample_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CountW-1:0]   cfg_data_i
);
  wis_cmd_t          dp_cmd;
  wis_sts_t          dp_sts;
  logic [IndexW-1:0] dp_index;
  logic [CountW-1:0] row_len;

  wis_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .sts_o(dp_sts), .weight_i, .uniform_i,
    .row_len_i(row_len), .index_o(dp_index)
  );

  wis_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .last_weight_i,
    .out_valid_o, .out_ready_i, .index_o, .status_o, .last_sample_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .dp_cmd_o(dp_cmd), .dp_sts_i(dp_sts), .dp_index_i(dp_index), .row_len_o(row_len)
  );
endmodule

// ===== rtl/wis_checker.sv =====
// Port checker for the weighted index sampler.
module wis_checker import wis_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IndexW-1:0]  index_o,
  input logic [StatusW-1:0] status_o,
  input logic               last_sample_o
);
  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken with result pending");
  a_err_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> index_o == '0) else $error("error index");
  a_norow_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StNoRow |-> !last_sample_o) else $error("no-row last");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(index_o)) else $error("hold");
endmodule

bind weighted_index_sampler_top wis_checker u_chk (.*);

// ===== verif/weighted_index_sampler_checker.sv =====
// Checker for the weighted index sampler: watches all channels, predicts draws, compares.
module weighted_index_sampler_checker import wis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                cmd_i,
  input  logic [WeightW-1:0]  weight_i,
  input  logic                last_weight_i,
  input  logic [UniformW-1:0] uniform_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [IndexW-1:0]   index_i,
  input  logic [StatusW-1:0]  status_i,
  input  logic                last_sample_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [CountW-1:0]   cfg_data_i,
  output int                  pending_o,
  output int                  checked_o,
  output int                  errors_o
);
  localparam int unsigned RowMax = 4096;
  localparam logic CmdLoad = 1'b0;

  typedef struct packed {
    logic [IndexW-1:0]  index;
    logic [StatusW-1:0] status;
    logic               last_sample;
  } draw_result_t;

  draw_result_t      expected_draws[$];
  logic [WeightW-1:0] row_weights[RowMax];
  logic [27:0]        row_prefix[RowMax];
  int unsigned        row_len;
  logic [CountW-1:0]  draws_seen;
  bit                 row_open;
  bit                 keep_drawn;
  logic [CountW-1:0]  draws_per_row;

  assign pending_o = expected_draws.size();

  function automatic draw_result_t sample_row(logic [UniformW-1:0] u);
    draw_result_t r;
    int unsigned lo, hi, mid, quota;
    logic [63:0] target, run;
    r = '0;
    r.status = StOk;
    quota = (draws_per_row == 0) ? 1 : draws_per_row;
    if (!row_open || row_len == 0) begin
      r.status = StNoRow;
      return r;
    end
    if (!keep_drawn && draws_seen >= row_len) begin
      r.status = StExhaust;
    end else begin
      target = 64'(u) * 64'(row_prefix[row_len-1]);
      lo = 0;
      hi = row_len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ((64'(row_prefix[mid]) << 24) >= target) hi = mid;
        else lo = mid + 1;
      end
      if (lo >= row_len) lo = 0;
      r.index = lo[IndexW-1:0];
      if (!keep_drawn) begin
        row_weights[lo] = '0;
        run = (lo > 0) ? 64'(row_prefix[lo-1]) : 64'd0;
        for (int unsigned i = lo; i < row_len; i++) begin
          run += row_weights[i];
          row_prefix[i] = run[27:0];
        end
      end
    end
    draws_seen = draws_seen + 1'b1;
    if (draws_seen >= quota) begin
      r.last_sample = 1'b1;
      row_open = 1'b0;
    end
    return r;
  endfunction

  function automatic void load_weight(logic [WeightW-1:0] w, logic last);
    if (row_open) begin
      row_open = 1'b0;
      row_len = 0;
      draws_seen = '0;
    end
    if (row_len < RowMax) begin
      row_weights[row_len] = w;
      row_prefix[row_len] = ((row_len > 0) ? row_prefix[row_len-1] : 28'd0) + w;
      row_len++;
    end
    if (last && row_len > 0) begin
      row_open = 1'b1;
      draws_seen = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_result_t want;
    int           bad;
    bad = 0;
    if (!rst_ni) begin
      expected_draws.delete();
      row_len = 0;
      draws_seen = '0;
      row_open = 1'b0;
      keep_drawn = 1'b1;
      draws_per_row = 13'd1;
      checked_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgWithRepl) keep_drawn = cfg_data_i[0];
        else draws_per_row = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CmdLoad) load_weight(weight_i, last_weight_i);
        else expected_draws.push_back(sample_row(uniform_i));
      end
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (expected_draws.size() == 0) begin
          $error("unexpected result: index %0d status %0d", index_i, status_i);
          bad++;
        end else begin
          want = expected_draws.pop_front();
          if (index_i !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, index_i);
            bad++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            bad++;
          end
          if (last_sample_i !== want.last_sample) begin
            $error("last_sample: expected %0d, got %0d", want.last_sample, last_sample_i);
            bad++;
          end
        end
      end
      errors_o <= errors_o + bad;
    end
  end
endmodule

// ===== verif/weighted_index_sampler_top_tb.sv =====
// Testbench top for the weighted index sampler: stimulus, flow control and verdict.
module weighted_index_sampler_top_tb;
  import wis_pkg::*;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDraw = 1'b1;
  localparam int   SettleCycles = 9000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CmdLoad;
  logic [WeightW-1:0]  weight = '0;
  logic                last_weight = 1'b0;
  logic [UniformW-1:0] uniform = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IndexW-1:0]   index;
  logic [StatusW-1:0]  status;
  logic                last_sample;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CfgWithRepl;
  logic [CountW-1:0]   cfg_data = '0;
  int                  pending, checked, errors;

  int  requests_sent = 0;
  bit  no_idle = 1'b0;
  int  long_hold = 0;
  bit  repl_mode = 1'b1;
  int  quota = 1;

  weighted_index_sampler_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .weight_i(weight), .last_weight_i(last_weight), .uniform_i(uniform),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .index_o(index), .status_o(status), .last_sample_o(last_sample),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  weighted_index_sampler_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .cmd_i(cmd), .weight_i(weight), .last_weight_i(last_weight), .uniform_i(uniform),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .index_i(index), .status_i(status), .last_sample_i(last_sample),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .checked_o(checked), .errors_o(errors)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 20_000_000);
    $display("[weighted_index_sampler_top] ERROR");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        @(posedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
      @(posedge clk) out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
    end
  end

  task automatic send_request(logic c, logic [WeightW-1:0] w, logic lw,
                              logic [UniformW-1:0] u);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(posedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
    end
    @(posedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    weight <= w;
    last_weight <= lw;
    uniform <= u;
    do @(negedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic settle();
    @(posedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CountW-1:0] data);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk) cfg_valid <= 1'b0;
    if (idx == CfgWithRepl) repl_mode = data[0];
    else quota = (data == 0) ? 1 : data;
  endtask

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return WeightW'($urandom_range(0, 15));
      default: return WeightW'($urandom);
    endcase
  endfunction

  function automatic logic [UniformW-1:0] pick_uniform();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return UniformW'($urandom);
    endcase
  endfunction

  task automatic load_row(int len, bit close);
    for (int i = 0; i < len; i++) begin
      send_request(CmdLoad, pick_weight(), close && (i == len - 1), UniformW'($urandom));
    end
  endtask

  task automatic draw(logic [UniformW-1:0] u);
    send_request(CmdDraw, WeightW'($urandom), 1'($urandom), u);
  endtask

  task automatic random_phase(int count);
    int len, n, stop;
    stop = requests_sent + count;
    while (requests_sent < stop) begin
      case ($urandom_range(0, 9))
        0: draw(pick_uniform());
        1: begin
          load_row($urandom_range(1, 5), 1'b0);
          draw(pick_uniform());
        end
        default: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
          load_row(len, 1'b1);
          n = repl_mode ? $urandom_range(1, (quota < 8) ? quota : 8)
                        : len + $urandom_range(0, 2);
          if (n > quota + 1) n = quota + 1;
          for (int i = 0; i < n; i++) draw(pick_uniform());
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: no row, zero total, zero uniform, top of range, closed row
    draw('0);
    send_request(CmdLoad, '0, 1'b1, '1);
    draw('1);
    draw(24'h123456);
    send_request(CmdLoad, '0, 1'b0, '0);
    send_request(CmdLoad, '1, 1'b0, '0);
    draw(24'h800000);
    send_request(CmdLoad, '1, 1'b1, '0);
    draw('1);
    write_reg(CfgWithRepl, 13'd0);
    write_reg(CfgSamples, 13'd4);
    send_request(CmdLoad, 16'd5, 1'b0, '0);
    send_request(CmdLoad, 16'd0, 1'b0, '0);
    send_request(CmdLoad, 16'd7, 1'b1, '0);
    draw('0);
    draw('1);
    draw(24'h400000);
    draw(24'h400000);
    // abandon a ready row with a fresh load
    send_request(CmdLoad, 16'd9, 1'b1, '0);
    draw('0);
    send_request(CmdLoad, 16'd3, 1'b1, '0);
    draw('1);
    // lower the quota below the draws already made
    write_reg(CfgWithRepl, 13'd1);
    write_reg(CfgSamples, 13'd8);
    send_request(CmdLoad, 16'd1, 1'b0, '0);
    send_request(CmdLoad, 16'd2, 1'b1, '0);
    draw('1);
    draw('0);
    draw(24'hABCDEF);
    write_reg(CfgSamples, 13'd2);
    draw('1);
    draw('1);

    // row overflow past the store depth, burst without idling
    write_reg(CfgSamples, 13'd3);
    no_idle = 1'b1;
    load_row(4100, 1'b1);
    draw('1);
    draw(24'h000001);
    draw(pick_uniform());
    no_idle = 1'b0;

    // receiver hold-off while draws keep coming
    write_reg(CfgSamples, 13'd4096);
    load_row(4, 1'b1);
    long_hold = 400;
    for (int i = 0; i < 30; i++) draw(pick_uniform());

    write_reg(CfgSamples, 13'd1);    random_phase(200);
    write_reg(CfgWithRepl, 13'd0);   random_phase(200);
    write_reg(CfgSamples, 13'd0);    random_phase(150);
    write_reg(CfgSamples, 13'd8191); no_idle = 1'b1; random_phase(150); no_idle = 1'b0;
    write_reg(CfgWithRepl, 13'd1);   random_phase(200);
    write_reg(CfgSamples, CountW'($urandom_range(2, 16))); random_phase(200);
    write_reg(CfgWithRepl, 13'd0);   random_phase(200);
    write_reg(CfgSamples, 13'd4096); random_phase(200);

    settle();
    $display("Sent %0d requests; checked %0d draws across both modes, quota extremes,",
             requests_sent, checked);
    $display("an overflowing row and a long output hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("[weighted_index_sampler_top] OK");
    end else begin
      $display("[weighted_index_sampler_top] ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/wis_pkg.sv
rtl/wis_datapath.sv
rtl/wis_ctrl.sv
rtl/weighted_index_sampler_top.sv
rtl/wis_checker.sv
verif/weighted_index_sampler_checker.sv
verif/weighted_index_sampler_top_tb.sv
